[hw/rtl/eapol_supplicant_pae_fsm_defines.svh]
// ----------------------------------------------------------------------------
// eapol supplicant pae defines
// assertion macros used by the rtl of the supplicant pae state machine
// ----------------------------------------------------------------------------
`ifndef EAPOL_SUPPLICANT_PAE_FSM_DEFINES_SVH
`define EAPOL_SUPPLICANT_PAE_FSM_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define EAPOL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define EAPOL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EAPOL_ASSERT(lbl, clk, rst_n, prop, msg)
`define EAPOL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hw/rtl/eapol_pkg.sv]
// ----------------------------------------------------------------------------
// eapol supplicant pae package
// state and transmit codes, register indexes and payload types
// ----------------------------------------------------------------------------
package eapol_pkg;

    localparam logic [2:0] ST_LOGOFF         = 3'd0;
    localparam logic [2:0] ST_DISCONNECTED   = 3'd1;
    localparam logic [2:0] ST_CONNECTING     = 3'd2;
    localparam logic [2:0] ST_ACQUIRED       = 3'd3;
    localparam logic [2:0] ST_AUTHENTICATING = 3'd4;
    localparam logic [2:0] ST_HELD           = 3'd5;
    localparam logic [2:0] ST_AUTHENTICATED  = 3'd6;

    localparam logic [2:0] TX_NONE     = 3'd0;
    localparam logic [2:0] TX_START    = 3'd1;
    localparam logic [2:0] TX_LOGOFF   = 3'd2;
    localparam logic [2:0] TX_RSP_ID   = 3'd3;
    localparam logic [2:0] TX_RSP_AUTH = 3'd4;

    localparam logic [8:0] NO_ID = 9'd256;
    localparam logic [7:0] START_COUNT_MAX = 8'd255;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_START    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HELD_PERIOD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTH_PERIOD  = 2'd3;

    localparam logic [7:0]  MAX_START_RST    = 8'd3;
    localparam logic [15:0] START_PERIOD_RST = 16'd30;
    localparam logic [15:0] HELD_PERIOD_RST  = 16'd60;
    localparam logic [15:0] AUTH_PERIOD_RST  = 16'd30;

    typedef struct packed {
        logic       initialize;
        logic       port_enabled;
        logic       user_logoff;
        logic       eap_success_rx;
        logic       eap_fail_rx;
        logic       req_id_rx;
        logic       req_auth_rx;
        logic [7:0] received_id;
        logic       tick;
    } t_in;

    typedef struct packed {
        logic [2:0] pae_state;
        logic       authorized;
        logic [2:0] tx_kind;
        logic [7:0] tx_id;
        logic [8:0] tx_prev_id;
    } t_out;

    typedef struct packed {
        logic [7:0]  max_start;
        logic [15:0] start_period;
        logic [15:0] held_period;
        logic [15:0] auth_period;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  state;
        logic [7:0]  start_count;
        logic        logoff_sent;
        logic        success;
        logic        fail;
        logic        req_id;
        logic        req_auth;
        logic [7:0]  last_rx_id;
        logic [8:0]  prev_id;
        logic        authorized;
        logic [15:0] start_timer;
        logic [15:0] held_timer;
        logic [15:0] auth_timer;
    } t_pae;

endpackage

[hw/rtl/eapol_supplicant_pae_fsm.sv]
// ----------------------------------------------------------------------------
// eapol supplicant pae state machine
// 802.1x supplicant port access entity, one result per request
// ----------------------------------------------------------------------------
// channel   direction  signals
// in        input      i_in_valid, o_in_stall, i_in_data
// out       output     o_out_valid, i_out_stall, o_out_data
// cfg       input      i_cfg_we, i_cfg_index, i_cfg_data
//
// one request per cycle unless the input stalls; the result shows in the cycle after it is taken
// the pae state update and the result register load at the same edge
// synchronous active-low reset puts the pae in disconnected, registers at defaults
// input stalls only while a result is held and the output side stalls
// ----------------------------------------------------------------------------
`include "eapol_supplicant_pae_fsm_defines.svh"

module eapol_supplicant_pae_fsm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  eapol_pkg::t_in                      i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output eapol_pkg::t_out                     o_out_data,
    input  logic                                i_cfg_we,
    input  logic [eapol_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [eapol_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import eapol_pkg::*;

    t_cfg r_cfg;
    t_pae r_pae;
    t_pae n_pae;
    t_out r_out;
    t_out n_out;
    logic r_out_valid;
    logic accept;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    eapol_step u_step (
        .i_cur  (r_pae),
        .i_item (i_in_data),
        .i_cfg  (r_cfg),
        .o_nxt  (n_pae),
        .o_res  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_start    <= MAX_START_RST;
            r_cfg.start_period <= START_PERIOD_RST;
            r_cfg.held_period  <= HELD_PERIOD_RST;
            r_cfg.auth_period  <= AUTH_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_START:    r_cfg.max_start    <= i_cfg_data[7:0];
                CFG_START_PERIOD: r_cfg.start_period <= i_cfg_data;
                CFG_HELD_PERIOD:  r_cfg.held_period  <= i_cfg_data;
                CFG_AUTH_PERIOD:  r_cfg.auth_period  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pae.state       <= ST_DISCONNECTED;
            r_pae.start_count <= 8'd0;
            r_pae.logoff_sent <= 1'b0;
            r_pae.success     <= 1'b0;
            r_pae.fail        <= 1'b0;
            r_pae.req_id      <= 1'b0;
            r_pae.req_auth    <= 1'b0;
            r_pae.last_rx_id  <= 8'd0;
            r_pae.prev_id     <= NO_ID;
            r_pae.authorized  <= 1'b0;
            r_pae.start_timer <= 16'd0;
            r_pae.held_timer  <= 16'd0;
            r_pae.auth_timer  <= 16'd0;
        end else if (accept) begin
            r_pae <= n_pae;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    `EAPOL_ASSERT(a_accept_gives_result, i_clk, i_rst_n, accept |=> o_out_valid, "request without result")
    `EAPOL_ASSERT(a_no_tx_no_prev, i_clk, i_rst_n, (o_out_valid && o_out_data.tx_kind == TX_NONE) |-> (o_out_data.tx_prev_id == NO_ID), "prev id without response")
    `EAPOL_ASSERT(a_state_matches_out, i_clk, i_rst_n, (o_out_valid && !$past(accept)) |-> (o_out_data.pae_state == r_pae.state), "held result out of step with state")
    `EAPOL_ASSERT_ALWAYS(a_reset_disconnected, i_clk, $past(!i_rst_n) |-> (r_pae.state == ST_DISCONNECTED && !r_out_valid), "reset did not disconnect")

endmodule

[hw/rtl/eapol_step.sv]
// ----------------------------------------------------------------------------
// eapol supplicant pae step
// next pae state and transmit result for one request
// ----------------------------------------------------------------------------
module eapol_step (
    input  eapol_pkg::t_pae i_cur,
    input  eapol_pkg::t_in  i_item,
    input  eapol_pkg::t_cfg i_cfg,
    output eapol_pkg::t_pae o_nxt,
    output eapol_pkg::t_out o_res
);
    import eapol_pkg::*;

    always_comb begin
        t_pae       s;
        logic       down;
        logic       logoff;
        logic       take;
        logic [2:0] tgt;
        logic [2:0] kind;
        logic [7:0] tx_id;
        logic [8:0] tx_prev;

        s = i_cur;
        if (i_item.eap_success_rx) s.success = 1'b1;
        if (i_item.eap_fail_rx) s.fail = 1'b1;
        if (i_item.req_id_rx) s.req_id = 1'b1;
        if (i_item.req_auth_rx) s.req_auth = 1'b1;
        if (i_item.req_id_rx || i_item.req_auth_rx) s.last_rx_id = i_item.received_id;

        if (i_item.tick) begin
            if (s.start_timer != 16'd0) s.start_timer = s.start_timer - 16'd1;
            if (s.held_timer != 16'd0) s.held_timer = s.held_timer - 16'd1;
            if (s.auth_timer != 16'd0) s.auth_timer = s.auth_timer - 16'd1;
        end

        down    = i_item.initialize || !i_item.port_enabled;
        logoff  = i_item.user_logoff;
        take    = 1'b1;
        tgt     = ST_DISCONNECTED;
        kind    = TX_NONE;
        tx_id   = 8'd0;
        tx_prev = NO_ID;

        // global rules first
        if (logoff && !s.logoff_sent && !down) begin
            tgt = ST_LOGOFF;
        end else if (down) begin
            tgt = ST_DISCONNECTED;
        end else if (s.fail && !logoff && !s.logoff_sent) begin
            tgt = ST_HELD;
        end else if (s.success && !logoff && !s.logoff_sent) begin
            tgt = ST_AUTHENTICATED;
        end else begin
            take = 1'b0;
            unique case (s.state)
                ST_LOGOFF: begin
                    if (!logoff) begin
                        take = 1'b1;
                        tgt  = ST_DISCONNECTED;
                    end
                end
                ST_CONNECTING: begin
                    if (s.start_timer == 16'd0 && s.start_count >= i_cfg.max_start) begin
                        take = 1'b1;
                        tgt  = ST_AUTHENTICATED;
                    end else if (s.req_id) begin
                        take = 1'b1;
                        tgt  = ST_ACQUIRED;
                    end else if (s.start_timer == 16'd0) begin
                        take = 1'b1;
                        tgt  = ST_CONNECTING;
                    end
                end
                ST_HELD: begin
                    if (s.held_timer == 16'd0) begin
                        take = 1'b1;
                        tgt  = ST_CONNECTING;
                    end else if (s.req_id) begin
                        take = 1'b1;
                        tgt  = ST_ACQUIRED;
                    end
                end
                ST_AUTHENTICATING: begin
                    if (s.req_auth) begin
                        take = 1'b1;
                        tgt  = ST_AUTHENTICATING;
                    end else if (s.req_id) begin
                        take = 1'b1;
                        tgt  = ST_ACQUIRED;
                    end else if (s.auth_timer == 16'd0) begin
                        take = 1'b1;
                        tgt  = ST_CONNECTING;
                    end
                end
                ST_ACQUIRED: begin
                    if (s.req_id) begin
                        take = 1'b1;
                        tgt  = ST_ACQUIRED;
                    end else if (s.req_auth) begin
                        take = 1'b1;
                        tgt  = ST_AUTHENTICATING;
                    end else if (s.auth_timer == 16'd0) begin
                        take = 1'b1;
                        tgt  = ST_CONNECTING;
                    end
                end
                ST_AUTHENTICATED: begin
                    if (s.req_id) begin
                        take = 1'b1;
                        tgt  = ST_ACQUIRED;
                    end
                end
                default: begin
                    // disconnected and the unused code
                    take = 1'b1;
                    tgt  = ST_CONNECTING;
                end
            endcase
        end

        // entry actions
        if (take) begin
            s.state = tgt;
            unique case (tgt)
                ST_LOGOFF: begin
                    kind          = TX_LOGOFF;
                    s.logoff_sent = 1'b1;
                    s.authorized  = 1'b0;
                end
                ST_CONNECTING: begin
                    s.start_timer = i_cfg.start_period;
                    if (s.start_count != START_COUNT_MAX) s.start_count = s.start_count + 8'd1;
                    s.req_id = 1'b0;
                    kind     = TX_START;
                end
                ST_ACQUIRED: begin
                    s.auth_timer  = i_cfg.auth_period;
                    s.start_count = 8'd0;
                    s.req_id      = 1'b0;
                    s.req_auth    = 1'b0;
                    kind          = TX_RSP_ID;
                    tx_id         = s.last_rx_id;
                    tx_prev       = s.prev_id;
                    s.prev_id     = {1'b0, s.last_rx_id};
                end
                ST_AUTHENTICATING: begin
                    s.auth_timer = i_cfg.auth_period;
                    s.req_auth   = 1'b0;
                    kind         = TX_RSP_AUTH;
                    tx_id        = s.last_rx_id;
                    tx_prev      = s.prev_id;
                    s.prev_id    = {1'b0, s.last_rx_id};
                end
                ST_HELD: begin
                    s.held_timer = i_cfg.held_period;
                    s.fail       = 1'b0;
                    s.success    = 1'b0;
                    s.authorized = 1'b0;
                end
                ST_AUTHENTICATED: begin
                    s.success    = 1'b0;
                    s.fail       = 1'b0;
                    s.authorized = 1'b1;
                end
                default: begin
                    s.state       = ST_DISCONNECTED;
                    s.success     = 1'b0;
                    s.fail        = 1'b0;
                    s.start_count = 8'd0;
                    s.logoff_sent = 1'b0;
                    s.prev_id     = NO_ID;
                    s.authorized  = 1'b0;
                end
            endcase
        end

        o_nxt            = s;
        o_res.pae_state  = s.state;
        o_res.authorized = s.authorized;
        o_res.tx_kind    = kind;
        o_res.tx_id      = tx_id;
        o_res.tx_prev_id = tx_prev;
    end

endmodule

[tb/eapol_supplicant_pae_fsm_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eapol supplicant pae state machine testbench
// drives requests through the valid/stall input channel, predicts each result
// with a behavioral copy of the pae and compares every field at the output;
// register settings change between phases while the block is idle, both sides
// idle in random bursts, and the last phase runs at full rate
// ----------------------------------------------------------------------------
module eapol_supplicant_pae_fsm_tb;
    import eapol_pkg::*;

    typedef enum int {PRF_QUIET_LINK, PRF_SESSION, PRF_NOISE} t_profile;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in                   in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_out                  out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    t_in  req_queue[$];
    t_out results_due[$];
    t_pae pae;
    t_cfg regs;

    bit   logoff_level;
    bit   quiet;
    int   gap_pct;
    int   stall_pct;
    int   gap_left;
    int   stall_left;
    int   idle_cycles;
    int   n_err;
    int   n_req;
    int   n_res;
    int   n_cfg;
    logic [7:0] states_seen;
    logic [7:0] frames_seen;

    eapol_supplicant_pae_fsm u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic t_out pae_advance(input t_in rq);
        t_out       rs;
        logic       down;
        logic       go;
        logic [2:0] tgt;
        if (rq.eap_success_rx) pae.success = 1'b1;
        if (rq.eap_fail_rx) pae.fail = 1'b1;
        if (rq.req_id_rx) pae.req_id = 1'b1;
        if (rq.req_auth_rx) pae.req_auth = 1'b1;
        if (rq.req_id_rx || rq.req_auth_rx) pae.last_rx_id = rq.received_id;
        if (rq.tick) begin
            if (pae.start_timer != 16'd0) pae.start_timer = pae.start_timer - 16'd1;
            if (pae.held_timer != 16'd0) pae.held_timer = pae.held_timer - 16'd1;
            if (pae.auth_timer != 16'd0) pae.auth_timer = pae.auth_timer - 16'd1;
        end
        rs.tx_kind    = TX_NONE;
        rs.tx_id      = '0;
        rs.tx_prev_id = NO_ID;

        // global rules first, then the rules of the current state
        down = rq.initialize || !rq.port_enabled;
        go   = 1'b1;
        tgt  = ST_DISCONNECTED;
        if (rq.user_logoff && !pae.logoff_sent && !down) begin
            tgt = ST_LOGOFF;
        end else if (down) begin
            tgt = ST_DISCONNECTED;
        end else if (pae.fail && !rq.user_logoff && !pae.logoff_sent) begin
            tgt = ST_HELD;
        end else if (pae.success && !rq.user_logoff && !pae.logoff_sent) begin
            tgt = ST_AUTHENTICATED;
        end else begin
            go = 1'b0;
            case (pae.state)
                ST_LOGOFF: if (!rq.user_logoff) begin
                    go  = 1'b1;
                    tgt = ST_DISCONNECTED;
                end
                ST_CONNECTING: begin
                    go = 1'b1;
                    if (pae.start_timer == 16'd0 && pae.start_count >= regs.max_start)
                        tgt = ST_AUTHENTICATED;
                    else if (pae.req_id) tgt = ST_ACQUIRED;
                    else if (pae.start_timer == 16'd0) tgt = ST_CONNECTING;
                    else go = 1'b0;
                end
                ST_HELD: begin
                    go = 1'b1;
                    if (pae.held_timer == 16'd0) tgt = ST_CONNECTING;
                    else if (pae.req_id) tgt = ST_ACQUIRED;
                    else go = 1'b0;
                end
                ST_AUTHENTICATING: begin
                    go = 1'b1;
                    if (pae.req_auth) tgt = ST_AUTHENTICATING;
                    else if (pae.req_id) tgt = ST_ACQUIRED;
                    else if (pae.auth_timer == 16'd0) tgt = ST_CONNECTING;
                    else go = 1'b0;
                end
                ST_ACQUIRED: begin
                    go = 1'b1;
                    if (pae.req_id) tgt = ST_ACQUIRED;
                    else if (pae.req_auth) tgt = ST_AUTHENTICATING;
                    else if (pae.auth_timer == 16'd0) tgt = ST_CONNECTING;
                    else go = 1'b0;
                end
                ST_AUTHENTICATED: if (pae.req_id) begin
                    go  = 1'b1;
                    tgt = ST_ACQUIRED;
                end
                default: begin
                    go  = 1'b1;
                    tgt = ST_CONNECTING;
                end
            endcase
        end

        // entry actions, self re-entry included
        if (go) begin
            pae.state = tgt;
            case (tgt)
                ST_LOGOFF: begin
                    rs.tx_kind      = TX_LOGOFF;
                    pae.logoff_sent = 1'b1;
                    pae.authorized  = 1'b0;
                end
                ST_CONNECTING: begin
                    pae.start_timer = regs.start_period;
                    if (pae.start_count < START_COUNT_MAX)
                        pae.start_count = pae.start_count + 8'd1;
                    pae.req_id = 1'b0;
                    rs.tx_kind = TX_START;
                end
                ST_ACQUIRED, ST_AUTHENTICATING: begin
                    pae.auth_timer = regs.auth_period;
                    pae.req_auth   = 1'b0;
                    if (tgt == ST_ACQUIRED) begin
                        pae.start_count = '0;
                        pae.req_id      = 1'b0;
                        rs.tx_kind      = TX_RSP_ID;
                    end else begin
                        rs.tx_kind = TX_RSP_AUTH;
                    end
                    rs.tx_id      = pae.last_rx_id;
                    rs.tx_prev_id = pae.prev_id;
                    pae.prev_id   = {1'b0, pae.last_rx_id};
                end
                ST_HELD: begin
                    pae.held_timer = regs.held_period;
                    pae.fail       = 1'b0;
                    pae.success    = 1'b0;
                    pae.authorized = 1'b0;
                end
                ST_AUTHENTICATED: begin
                    pae.success    = 1'b0;
                    pae.fail       = 1'b0;
                    pae.authorized = 1'b1;
                end
                default: begin
                    pae.state       = ST_DISCONNECTED;
                    pae.success     = 1'b0;
                    pae.fail        = 1'b0;
                    pae.start_count = '0;
                    pae.logoff_sent = 1'b0;
                    pae.prev_id     = NO_ID;
                    pae.authorized  = 1'b0;
                end
            endcase
        end
        rs.pae_state  = pae.state;
        rs.authorized = pae.authorized;
        return rs;
    endfunction

    function automatic t_in req(input bit init, input bit en, input bit logoff,
                                input bit succ, input bit fail, input bit rid,
                                input bit rauth, input logic [7:0] id, input bit tick);
        t_in rq;
        rq.initialize     = init;
        rq.port_enabled   = en;
        rq.user_logoff    = logoff;
        rq.eap_success_rx = succ;
        rq.eap_fail_rx    = fail;
        rq.req_id_rx      = rid;
        rq.req_auth_rx    = rauth;
        rq.received_id    = id;
        rq.tick           = tick;
        return rq;
    endfunction

    function automatic t_in rand_req(input t_profile prf);
        t_in         rq;
        logic [31:0] r;
        r  = $urandom;
        rq = r[$bits(t_in)-1:0];
        if (prf == PRF_QUIET_LINK) begin
            rq.initialize     = 1'b0;
            rq.port_enabled   = 1'b1;
            rq.user_logoff    = 1'b0;
            rq.eap_success_rx = 1'b0;
            rq.eap_fail_rx    = 1'b0;
            rq.req_id_rx      = 1'b0;
            rq.req_auth_rx    = 1'b0;
        end else if (prf == PRF_SESSION) begin
            // logoff is a level: held for short stretches
            if ($urandom_range(0, logoff_level ? 5 : 59) == 0) logoff_level = !logoff_level;
            rq.initialize     = ($urandom_range(0, 149) == 0);
            rq.port_enabled   = ($urandom_range(0, 99) != 0);
            rq.user_logoff    = logoff_level;
            rq.eap_success_rx = ($urandom_range(0, 24) == 0);
            rq.eap_fail_rx    = ($urandom_range(0, 29) == 0);
            rq.req_id_rx      = ($urandom_range(0, 5) == 0);
            rq.req_auth_rx    = ($urandom_range(0, 4) == 0);
        end
        return rq;
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 5;
            default: return 25;
        endcase
    endfunction

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_MAX_START:    regs.max_start    = val[7:0];
            CFG_START_PERIOD: regs.start_period = val;
            CFG_HELD_PERIOD:  regs.held_period  = val;
            CFG_AUTH_PERIOD:  regs.auth_period  = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [7:0] ms, input logic [15:0] sp,
                            input logic [15:0] hp, input logic [15:0] ap);
        program_reg(CFG_MAX_START, {8'd0, ms});
        program_reg(CFG_START_PERIOD, sp);
        program_reg(CFG_HELD_PERIOD, hp);
        program_reg(CFG_AUTH_PERIOD, ap);
        cfg_we <= 1'b0;
        n_cfg++;
    endtask

    // sampled on the falling edge so the driver's updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (!(req_queue.size() == 0 && !in_valid && results_due.size() == 0))
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic run_phase(input int n, input int noise_pct);
        gap_pct   = quiet ? 0 : pick_pct();
        stall_pct = quiet ? 0 : pick_pct();
        repeat (n) begin
            if ($urandom_range(0, 99) < noise_pct) req_queue.push_back(rand_req(PRF_NOISE));
            else req_queue.push_back(rand_req(PRF_SESSION));
        end
        wait_drained();
    endtask

    function automatic logic [15:0] rand_period();
        if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 16'hffff));
        return 16'($urandom_range(0, 8));
    endfunction

    // request driver
    always @(posedge clk) begin : drv
        t_out res;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                res = pae_advance(in_data);
                results_due.push_back(res);
                n_req++;
            end
            if (!in_valid || !in_stall) begin
                if (!quiet && gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
                    gap_left = $urandom_range(0, 9);
                    in_valid <= 1'b0;
                end else if (req_queue.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data  <= req_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin : mon
        t_out want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                n_res++;
                states_seen[out_data.pae_state] = 1'b1;
                frames_seen[out_data.tx_kind]   = 1'b1;
                if (results_due.size() == 0) begin
                    $error("result with no request pending: %h", out_data);
                    n_err++;
                end else begin
                    want = results_due.pop_front();
                    if (out_data.pae_state !== want.pae_state) begin
                        $error("pae_state: expected %0d, got %0d",
                               want.pae_state, out_data.pae_state);
                        n_err++;
                    end
                    if (out_data.authorized !== want.authorized) begin
                        $error("authorized: expected %0d, got %0d",
                               want.authorized, out_data.authorized);
                        n_err++;
                    end
                    if (out_data.tx_kind !== want.tx_kind) begin
                        $error("tx_kind: expected %0d, got %0d", want.tx_kind, out_data.tx_kind);
                        n_err++;
                    end
                    if (out_data.tx_id !== want.tx_id) begin
                        $error("tx_id: expected %0d, got %0d", want.tx_id, out_data.tx_id);
                        n_err++;
                    end
                    if (out_data.tx_prev_id !== want.tx_prev_id) begin
                        $error("tx_prev_id: expected %0d, got %0d",
                               want.tx_prev_id, out_data.tx_prev_id);
                        n_err++;
                    end
                end
            end
            if (!quiet && stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        states_seen = '0;
        frames_seen = '0;
        gap_pct     = 0;
        stall_pct   = 0;

        pae              = '0;
        pae.state        = ST_DISCONNECTED;
        pae.prev_id      = NO_ID;
        regs.max_start    = MAX_START_RST;
        regs.start_period = START_PERIOD_RST;
        regs.held_period  = HELD_PERIOD_RST;
        regs.auth_period  = AUTH_PERIOD_RST;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk through every state and frame kind at reset settings
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
        req_queue.push_back(req(0, 1, 0, 0, 0, 0, 0, 8'd0, 0));
        req_queue.push_back(req(0, 1, 0, 0, 0, 1, 0, 8'd255, 1));
        req_queue.push_back(req(0, 1, 0, 0, 0, 0, 1, 8'd0, 0));
        // both request pulses together
        req_queue.push_back(req(0, 1, 0, 0, 0, 1, 1, 8'h5a, 1));
        req_queue.push_back(req(0, 1, 0, 1, 0, 0, 0, 8'd0, 0));
        req_queue.push_back(req(0, 1, 0, 0, 0, 0, 0, 8'd0, 1));
        req_queue.push_back(req(0, 1, 0, 0, 1, 0, 0, 8'd0, 0));
        req_queue.push_back(req(0, 1, 0, 0, 0, 0, 0, 8'd0, 1));
        req_queue.push_back(req(0, 1, 0, 0, 0, 1, 0, 8'd1, 1));
        req_queue.push_back(req(0, 1, 1, 0, 0, 0, 0, 8'd0, 0));
        req_queue.push_back(req(0, 1, 1, 1, 1, 0, 0, 8'd0, 1));
        req_queue.push_back(req(0, 1, 0, 0, 0, 0, 0, 8'd0, 0));
        req_queue.push_back(req(0, 1, 0, 0, 0, 0, 0, 8'd0, 0));
        // held in disconnected by initialize and by a down link
        req_queue.push_back(req(1, 1, 0, 0, 0, 0, 0, 8'd0, 0));
        req_queue.push_back(req(1, 1, 0, 0, 0, 0, 0, 8'd0, 1));
        req_queue.push_back(req(0, 0, 1, 0, 0, 0, 0, 8'd0, 0));
        req_queue.push_back(req(1, 0, 1, 1, 1, 1, 1, 8'd255, 1));
        req_queue.push_back(req(0, 1, 0, 0, 0, 0, 0, 8'd0, 1));
        req_queue.push_back(req(0, 1, 0, 0, 0, 1, 0, 8'd0, 0));
        req_queue.push_back(req(0, 1, 0, 0, 0, 0, 0, 8'd0, 1));
        wait_drained();

        // start count runs up to saturation with zero periods
        set_regs(8'd255, 16'd0, 16'd0, 16'd0);
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
        repeat (270) req_queue.push_back(rand_req(PRF_QUIET_LINK));
        run_phase(30, 10);

        // max start of zero, one-tick timeouts
        set_regs(8'd0, 16'd1, 16'd1, 16'd1);
        run_phase(120, 10);

        set_regs(8'd1, 16'hffff, 16'hffff, 16'hffff);
        run_phase(120, 30);

        repeat (5) begin
            set_regs(8'($urandom_range(1, 6)), rand_period(), rand_period(), rand_period());
            run_phase(100, 10);
        end

        // full rate on both sides
        quiet = 1'b1;
        set_regs(MAX_START_RST, START_PERIOD_RST, HELD_PERIOD_RST, AUTH_PERIOD_RST);
        run_phase(100, 10);

        $display("%0d requests, %0d results checked across %0d register settings",
                 n_req, n_res, n_cfg);
        $display("states reached %b, frame kinds sent %b", states_seen[6:0], frames_seen[4:0]);
        if (n_err == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
